// ----- hdl/sorted_min_stack_macros.svh -----
// Assertion macros shared by the sorted minimum stack modules.
`ifndef SORTED_MIN_STACK_MACROS_SVH
`define SORTED_MIN_STACK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sms_pkg.sv -----
// Package with the types and constants of the sorted minimum stack.
`default_nettype none

package sms_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CMD_W  = 2;

   localparam logic signed [DATA_W-1:0] EMPTY_TOP = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_code_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hdl/sms_if.sv -----
// Request and response channel interfaces of the sorted minimum stack.
`default_nettype none

interface sms_req_if;
   import sms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface sms_rsp_if;
   import sms_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] top_value;
   logic                     is_empty;
   logic                     overflow;

   modport source (output valid, output top_value, output is_empty, output overflow,
                   input ready);
   modport sink   (input valid, input top_value, input is_empty, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/sms_ctrl.sv -----
// Controller state machine that sequences requests and owns the response valid.
`default_nettype none

`include "sorted_min_stack_macros.svh"

module sms_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output sms_pkg::ctrl_cmd_type      cmd,
   input  wire sms_pkg::dp_status_type status
);
   import sms_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = !rsp_valid_ff || rsp_ready;
            if (cmd.execute) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SMS_ASSERT_NEXT(a_accept_leads_to_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC, "accepted request did not move to execution")
   `SMS_ASSERT_SAME(a_no_accept_while_exec, clock, reset, cmd.execute, !req_ready, "request accepted while executing")
   `SMS_ASSERT_SAME(a_status_consistent, clock, reset, status.full, !status.empty, "store reported full and empty at once")

endmodule

`default_nettype wire

// ----- hdl/sms_datapath.sv -----
// Datapath with the row of sorted cells, the request registers and the result register.
`default_nettype none

`include "sorted_min_stack_macros.svh"

module sms_datapath #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sms_pkg::ctrl_cmd_type         cmd,
   output sms_pkg::dp_status_type             status,
   input  wire logic [sms_pkg::CMD_W-1:0]     req_command,
   input  wire logic signed [sms_pkg::DATA_W-1:0] req_value,
   output logic signed [sms_pkg::DATA_W-1:0]  rsp_top_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_overflow
);
   import sms_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [CMD_W-1:0]         command_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [CW-1:0]            count_ff, count_in;
   logic [DEPTH-1:0]         below;
   logic                     full, empty, do_push, do_pop;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic                     is_empty_ff, overflow_ff, overflow_in;
   cmd_code_type             code;

   assign code    = cmd_code_type'(command_ff);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = (code == CMD_PUSH) && !full;
   assign do_pop  = (code == CMD_POP) && !empty;

   genvar g;
   for (g = 0; g < DEPTH; g++) begin : g_cell
      assign below[g] = (CW'(g) < count_ff) && (entries_ff[g] < value_ff);

      always_comb begin
         entries_in[g] = entries_ff[g];
         if (do_push) begin
            if (below[g]) begin
               entries_in[g] = entries_ff[g];
            end else begin
               if (g == 0) begin
                  entries_in[g] = value_ff;
               end else if (below[(g == 0) ? 0 : g - 1]) begin
                  entries_in[g] = value_ff;
               end else begin
                  entries_in[g] = entries_ff[(g == 0) ? 0 : g - 1];
               end
            end
         end else if (do_pop) begin
            entries_in[g] = entries_ff[(g == DEPTH - 1) ? g : g + 1];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            entries_ff[g] <= entries_in[g];
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = 1'b0;
      unique case (code)
         CMD_PUSH: begin
            overflow_in = full;
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (!empty) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      top_in = (count_in == '0) ? EMPTY_TOP : entries_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         value_ff   <= req_value;
      end
      if (cmd.execute) begin
         top_ff      <= top_in;
         is_empty_ff <= (count_in == '0);
         overflow_ff <= overflow_in;
      end
   end

   assign status.full    = full;
   assign status.empty   = empty;
   assign rsp_top_value  = top_ff;
   assign rsp_is_empty   = is_empty_ff;
   assign rsp_overflow   = overflow_ff;

   `SMS_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "stored count exceeds the depth")
   `SMS_ASSERT_NEXT(a_push_top_not_above, clock, reset, cmd.execute && do_push, top_ff <= $past(value_ff), "top is larger than a value just pushed")

endmodule

`default_nettype wire

// ----- hdl/sorted_min_stack.sv -----
// Top level of the sorted minimum stack: controller, datapath and channel wiring.
//
//   channel   direction  payload
//   req_bus   in         command, value
//   rsp_bus   out        top_value, is_empty, overflow
//
// A request is accepted in the idle state and executed once the response slot is free,
// and no new request is taken before that; the cell row updates all entries at once.
// Reset clears the stored count and the response valid; the cell contents are not reset.
// A stalled response holds the next request in execution until the response is taken.
`default_nettype none

module sorted_min_stack #(
   parameter int unsigned DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   sms_req_if.sink  req_bus,
   sms_rsp_if.source rsp_bus
);
   import sms_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   sms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sms_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_bus.command),
      .req_value     (req_bus.value),
      .rsp_top_value (rsp_bus.top_value),
      .rsp_is_empty  (rsp_bus.is_empty),
      .rsp_overflow  (rsp_bus.overflow)
   );

endmodule

`default_nettype wire

// ----- tb/sorted_min_stack_tb.sv -----
// Self-checking testbench for the sorted minimum stack with randomised request and response flow.
module sorted_min_stack_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sms_pkg::*;

   localparam int unsigned DEPTH       = 16;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_OFF    = 400;
   localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MOST_POSITIVE = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic                     is_empty;
      logic                     overflow;
   } stack_result_type;

   class min_store_scoreboard;
      logic signed [DATA_W-1:0] sorted_vals[$];
      stack_result_type         awaited[$];
      int unsigned              capacity;
      int unsigned              mismatches;

      function new(int unsigned capacity);
         this.capacity = capacity;
         mismatches = 0;
      endfunction

      function int unsigned occupancy();
         return sorted_vals.size();
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function int unsigned failures();
         return mismatches + awaited.size();
      endfunction

      function void note_request(cmd_code_type cmd, logic signed [DATA_W-1:0] val);
         int               pos;
         stack_result_type res;
         res.overflow = 1'b0;
         case (cmd)
            CMD_PUSH: begin
               if (sorted_vals.size() >= capacity) begin
                  res.overflow = 1'b1;
               end else begin
                  pos = 0;
                  while (pos < sorted_vals.size() && sorted_vals[pos] < val) pos++;
                  sorted_vals.insert(pos, val);
               end
            end
            CMD_POP: begin
               if (sorted_vals.size() != 0) void'(sorted_vals.pop_front());
            end
            default: ;
         endcase
         if (sorted_vals.size() == 0) begin
            res.top_value = EMPTY_TOP;
            res.is_empty  = 1'b1;
         end else begin
            res.top_value = sorted_vals[0];
            res.is_empty  = 1'b0;
         end
         awaited.push_back(res);
      endfunction

      function void report(string what, stack_result_type want, stack_result_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%0t: %s: expected top %0d empty %0b overflow %0b, ",
                      "got top %0d empty %0b overflow %0b"},
                     $time, what, want.top_value, want.is_empty, want.overflow,
                     got.top_value, got.is_empty, got.overflow);
      endfunction

      function void check_response(stack_result_type got);
         stack_result_type want;
         if (awaited.size() == 0) begin
            report("response with no request outstanding", '0, got);
         end else begin
            want = awaited.pop_front();
            if (got.top_value !== want.top_value || got.is_empty !== want.is_empty ||
                got.overflow !== want.overflow)
               report("response mismatch", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   sms_req_if req_bus ();
   sms_rsp_if rsp_bus ();

   sorted_min_stack #(.DEPTH(DEPTH)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   min_store_scoreboard ledger = new(DEPTH);

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned sent_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned hold_off_left = 0;
   bit          hold_off_pending = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_min_stack verification failed");
         $finish;
      end
   end

   // The receiver samples accepted responses and drives ready, including the long hold-off.
   always @(posedge clock) begin : response_side
      stack_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.top_value = rsp_bus.top_value;
         got.is_empty  = rsp_bus.is_empty;
         got.overflow  = rsp_bus.overflow;
         ledger.check_response(got);
      end
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_off_left    = HOLD_OFF;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(cmd_code_type cmd, logic signed [DATA_W-1:0] val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.value   <= val;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_request(cmd, val);
      sent_count++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return MOST_NEGATIVE;
         1:       return MOST_POSITIVE;
         2, 3, 4: return $urandom;
         default: return int'($urandom_range(12)) - 6;
      endcase
   endfunction

   function automatic cmd_code_type pick_command();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) return CMD_PUSH;
      if (roll < 80) return CMD_POP;
      if (roll < 90) return CMD_QUERY;
      return CMD_SPARE;
   endfunction

   // Mixes runs that fill the store past full, runs that drain it past empty, and random bursts.
   task automatic run_random(int unsigned items);
      int unsigned stop_at;
      int unsigned burst;
      stop_at = sent_count + items;
      while (sent_count < stop_at) begin
         case ($urandom_range(9))
            0, 1: begin
               while (ledger.occupancy() < DEPTH) begin
                  if ($urandom_range(7) == 0) send_request(CMD_QUERY, $urandom);
                  send_request(CMD_PUSH, pick_value());
               end
               repeat ($urandom_range(3, 1)) send_request(CMD_PUSH, pick_value());
            end
            2, 3: begin
               while (ledger.occupancy() != 0) send_request(CMD_POP, $urandom);
               repeat ($urandom_range(2, 1)) send_request(CMD_POP, $urandom);
            end
            default: begin
               burst = $urandom_range(20, 8);
               repeat (burst) send_request(pick_command(), pick_value());
            end
         endcase
      end
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_QUERY;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 64;
      send_request(CMD_QUERY, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_PUSH, MOST_NEGATIVE);
      send_request(CMD_PUSH, MOST_POSITIVE);
      send_request(CMD_PUSH, '0);
      send_request(CMD_PUSH, -1);
      send_request(CMD_PUSH, '0);
      send_request(CMD_PUSH, '0);
      send_request(CMD_QUERY, MOST_NEGATIVE);
      send_request(CMD_SPARE, 32'sh5a5a_a5a5);
      repeat (7) send_request(CMD_POP, '1);
      send_request(CMD_QUERY, '1);

      run_random(600);
      send_idle_pct = 64;
      recv_idle_pct = 30;
      run_random(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_pending = 1'b1;
      run_random(600);
      req_bus.valid <= 1'b0;

      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.failures() == 0) begin
         $display("sorted_min_stack verification clean");
      end else begin
         $display("sorted_min_stack verification failed");
      end
      $finish;
   end

endmodule
